[hw/rtl/tre_pkg.sv]
package tre_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VA_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VA_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VB_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VB_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VC_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VC_Y = 3'd5;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef struct packed {
    logic last;   // final pixel of the box scan
    logic empty;  // box has no area, coverage forced off
  } scan_tag_t;

endpackage

[hw/rtl/tre_setup.sv]
module tre_setup #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  output logic [COORD_BITS-1:0]          x1_r,
  output logic [COORD_BITS-1:0]          y1_r,
  output logic [COORD_BITS-1:0]          x2_r,
  output logic [COORD_BITS-1:0]          y2_r,
  output logic [COORD_BITS-1:0]          x3_r,
  output logic [COORD_BITS-1:0]          y3_r,
  output logic [COORD_BITS-1:0]          minx_r,
  output logic [COORD_BITS-1:0]          maxx_r,
  output logic [COORD_BITS-1:0]          miny_r,
  output logic [COORD_BITS-1:0]          maxy_r,
  output logic                           empty_r
);

  logic [COORD_BITS-1:0] va_x_r, va_y_r, vb_x_r, vb_y_r, vc_x_r, vc_y_r;
  logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, tx, ty;
  logic [COORD_BITS-1:0] minx_nxt, maxx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_x_r <= '0;
      va_y_r <= '0;
      vb_x_r <= '0;
      vb_y_r <= '0;
      vc_x_r <= '0;
      vc_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tre_pkg::REG_VA_X: va_x_r <= cfg_wdata;
        tre_pkg::REG_VA_Y: va_y_r <= cfg_wdata;
        tre_pkg::REG_VB_X: vb_x_r <= cfg_wdata;
        tre_pkg::REG_VB_Y: vb_y_r <= cfg_wdata;
        tre_pkg::REG_VC_X: vc_x_r <= cfg_wdata;
        tre_pkg::REG_VC_Y: vc_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // three-swap sort by y
  always_comb begin
    ax = va_x_r; ay = va_y_r;
    bx = vb_x_r; by = vb_y_r;
    cx = vc_x_r; cy = vc_y_r;
    tx = '0;     ty = '0;
    if (ay > by) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    if (by > cy) begin
      tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty;
    end
    if (ay > by) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    minx_nxt = ax;
    maxx_nxt = ax;
    if (bx < minx_nxt) minx_nxt = bx;
    if (cx < minx_nxt) minx_nxt = cx;
    if (bx > maxx_nxt) maxx_nxt = bx;
    if (cx > maxx_nxt) maxx_nxt = cx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r    <= '0;
      y1_r    <= '0;
      x2_r    <= '0;
      y2_r    <= '0;
      x3_r    <= '0;
      y3_r    <= '0;
      minx_r  <= '0;
      maxx_r  <= '0;
      miny_r  <= '0;
      maxy_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      x1_r    <= ax;
      y1_r    <= ay;
      x2_r    <= bx;
      y2_r    <= by;
      x3_r    <= cx;
      y3_r    <= cy;
      minx_r  <= minx_nxt;
      maxx_r  <= maxx_nxt;
      miny_r  <= ay;
      maxy_r  <= cy;
      empty_r <= (minx_nxt == maxx_nxt) || (ay == cy);
    end
  end

endmodule

[hw/rtl/tre_front.sv]
module tre_front #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    restart,
  input  logic [COORD_BITS-1:0]   minx,
  input  logic [COORD_BITS-1:0]   maxx,
  input  logic [COORD_BITS-1:0]   miny,
  input  logic [COORD_BITS-1:0]   maxy,
  input  logic                    empty,
  output logic [COORD_BITS-1:0]   col,
  output logic [COORD_BITS-1:0]   row,
  output tre_pkg::scan_tag_t      tag
);

  logic [COORD_BITS-1:0] col_r, row_r, col_nxt, row_nxt;
  logic                  active_r, active_nxt;
  logic                  start;
  logic                  row_end, col_end;
  logic [COORD_BITS:0]   col_inc, row_inc;

  always_comb begin
    start = restart || !active_r || (col_r < minx) || (col_r >= maxx) ||
            (row_r < miny) || (row_r >= maxy);
    col = start ? minx : col_r;
    row = start ? miny : row_r;
    if (empty) begin
      col = minx;
      row = miny;
    end
    col_inc = {1'b0, col} + 1'b1;
    row_inc = {1'b0, row} + 1'b1;
    col_end = (col_inc == {1'b0, maxx});
    row_end = (row_inc == {1'b0, maxy});
    tag.empty = empty;
    tag.last  = empty || (col_end && row_end);

    // wrap to the box corner after the last pixel
    if (tag.last) begin
      col_nxt    = minx;
      row_nxt    = miny;
      active_nxt = 1'b0;
    end else if (col_end) begin
      col_nxt    = minx;
      row_nxt    = row_inc[COORD_BITS-1:0];
      active_nxt = 1'b1;
    end else begin
      col_nxt    = col_inc[COORD_BITS-1:0];
      row_nxt    = row;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

[hw/rtl/tre_queue.sv]
module tre_queue #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [COORD_BITS-1:0]   push_col,
  input  logic [COORD_BITS-1:0]   push_row,
  input  tre_pkg::scan_tag_t      push_tag,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output logic [COORD_BITS-1:0]   pop_col,
  output logic [COORD_BITS-1:0]   pop_row,
  output tre_pkg::scan_tag_t      pop_tag
);

  logic [COORD_BITS-1:0]          col_mem [tre_pkg::QUEUE_DEPTH];
  logic [COORD_BITS-1:0]          row_mem [tre_pkg::QUEUE_DEPTH];
  tre_pkg::scan_tag_t             tag_mem [tre_pkg::QUEUE_DEPTH];
  logic [tre_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [tre_pkg::QPTR_W:0]       count_r;
  logic                           do_push, do_pop;

  assign full      = (count_r == (tre_pkg::QPTR_W+1)'(tre_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  assign pop_col = col_mem[rd_ptr_r];
  assign pop_row = row_mem[rd_ptr_r];
  assign pop_tag = tag_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      col_mem[wr_ptr_r] <= push_col;
      row_mem[wr_ptr_r] <= push_row;
      tag_mem[wr_ptr_r] <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/tre_back.sv]
module tre_back #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [COORD_BITS-1:0]   x1,
  input  logic [COORD_BITS-1:0]   y1,
  input  logic [COORD_BITS-1:0]   x2,
  input  logic [COORD_BITS-1:0]   y2,
  input  logic [COORD_BITS-1:0]   x3,
  input  logic [COORD_BITS-1:0]   y3,
  input  logic                    q_not_empty,
  input  logic [COORD_BITS-1:0]   q_col,
  input  logic [COORD_BITS-1:0]   q_row,
  input  tre_pkg::scan_tag_t      q_tag,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_BITS-1:0]   out_pixel_x,
  output logic [COORD_BITS-1:0]   out_pixel_y,
  output logic                    out_covered,
  output logic                    out_last
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned EW = PW + 1;

  logic                  advance;
  logic                  s1_valid_r;
  logic [COORD_BITS-1:0] s1_col_r, s1_row_r;
  tre_pkg::scan_tag_t    s1_tag_r;
  logic signed [PW-1:0]  pa_r [3];
  logic signed [PW-1:0]  pb_r [3];
  logic [2:0]            neg, pos;
  logic                  out_valid_r, out_covered_r, out_last_r;
  logic [COORD_BITS-1:0] out_col_r, out_row_r;
  logic [COORD_BITS-1:0] px [3];
  logic [COORD_BITS-1:0] py [3];
  logic [COORD_BITS-1:0] qx [3];
  logic [COORD_BITS-1:0] qy [3];

  // whole pipe holds while the output word is stalled
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_not_empty;

  assign px[0] = x1; assign py[0] = y1; assign qx[0] = x2; assign qy[0] = y2;
  assign px[1] = x2; assign py[1] = y2; assign qx[1] = x3; assign qy[1] = y3;
  assign px[2] = x3; assign py[2] = y3; assign qx[2] = x1; assign qy[2] = y1;

  for (genvar e = 0; e < 3; e++) begin : g_edge
    logic signed [DW-1:0] dx, dy, ry, rx;
    logic signed [EW-1:0] ev;

    assign dx = $signed({1'b0, px[e]}) - $signed({1'b0, qx[e]});
    assign dy = $signed({1'b0, py[e]}) - $signed({1'b0, qy[e]});
    assign ry = $signed({1'b0, q_row}) - $signed({1'b0, py[e]});
    assign rx = $signed({1'b0, q_col}) - $signed({1'b0, px[e]});

    always_ff @(posedge clk) begin
      if (advance) begin
        pa_r[e] <= dx * ry;
        pb_r[e] <= dy * rx;
      end
    end

    assign ev     = EW'(pa_r[e]) - EW'(pb_r[e]);
    assign neg[e] = ev[EW-1];
    assign pos[e] = !ev[EW-1] && (ev != '0);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col_r      <= q_col;
      s1_row_r      <= q_row;
      s1_tag_r      <= q_tag;
      out_col_r     <= s1_col_r;
      out_row_r     <= s1_row_r;
      out_last_r    <= s1_tag_r.last;
      out_covered_r <= !s1_tag_r.empty && ((&neg) || (&pos));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= q_pop;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_col_r;
  assign out_pixel_y = out_row_r;
  assign out_covered = out_covered_r;
  assign out_last    = out_last_r;

endmodule

[hw/rtl/triangle_edge_rasterizer_top.sv]
// Edge-function triangle scan generator. Write the three vertices through the
// cfg port (index 0..5: a.x, a.y, b.x, b.y, c.x, c.y). A write reaches the
// scan through the vertex registers and then the sorted setup registers. Each
// input word (restart=1 jumps to the top-left of the bounding box, restart=0
// steps one pixel) yields one output word with the pixel position, a coverage
// bit for pixels strictly inside the triangle on every side (either winding) and a last
// flag on the final pixel of [min,max) x [min,max). An empty box gives its
// corner with covered=0 and last=1. Throughput is one pixel per clock while no
// stall holds the pipe. A result passes the queue entry, the edge multiplier
// stage and the output register in turn. A four-word queue between scan
// control and edge evaluation absorbs stalls.
module triangle_edge_rasterizer_top #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          out_pixel_x,
  output logic [COORD_BITS-1:0]          out_pixel_y,
  output logic                           out_covered,
  output logic                           out_last
);

  logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;
  logic [COORD_BITS-1:0] minx, maxx, miny, maxy;
  logic                  empty;
  logic                  accept, q_full, q_pop, q_not_empty;
  logic [COORD_BITS-1:0] f_col, f_row, q_col, q_row;
  tre_pkg::scan_tag_t    f_tag, q_tag;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  tre_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .x1_r     (x1),
    .y1_r     (y1),
    .x2_r     (x2),
    .y2_r     (y2),
    .x3_r     (x3),
    .y3_r     (y3),
    .minx_r   (minx),
    .maxx_r   (maxx),
    .miny_r   (miny),
    .maxy_r   (maxy),
    .empty_r  (empty)
  );

  tre_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .restart(in_restart),
    .minx   (minx),
    .maxx   (maxx),
    .miny   (miny),
    .maxy   (maxy),
    .empty  (empty),
    .col    (f_col),
    .row    (f_row),
    .tag    (f_tag)
  );

  tre_queue #(.COORD_BITS(COORD_BITS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_col (f_col),
    .push_row (f_row),
    .push_tag (f_tag),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_col  (q_col),
    .pop_row  (q_row),
    .pop_tag  (q_tag)
  );

  tre_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .x1         (x1),
    .y1         (y1),
    .x2         (x2),
    .y2         (y2),
    .x3         (x3),
    .y3         (y3),
    .q_not_empty(q_not_empty),
    .q_col      (q_col),
    .q_row      (q_row),
    .q_tag      (q_tag),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_covered(out_covered),
    .out_last   (out_last)
  );

endmodule
